// ===== design/fks_pkg.sv =====
`timescale 1ns / 1ps
// fks_pkg: widths, constants, command/status types and hash helpers for the
// FNV-1a key shard selector. No dependencies.
package fks_pkg;

    localparam int unsigned HASH_W         = 64;
    localparam int unsigned BYTE_W         = 8;
    localparam int unsigned CFG_W          = 11;
    localparam int unsigned IDX_W          = 10;
    localparam int unsigned MAX_SHARDS_DEF = 1024;

    // remainder unit: bits of the dividend consumed per cycle
    localparam int unsigned MOD_BITS  = 4;
    localparam int unsigned MOD_STEPS = HASH_W / MOD_BITS;
    localparam int unsigned MOD_CNT_W = $clog2(MOD_STEPS);

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
    localparam logic [BYTE_W-1:0] HYPHEN    = 8'h2D;
    localparam logic [BYTE_W-1:0] UPPER_A   = 8'h41;
    localparam logic [BYTE_W-1:0] UPPER_Z   = 8'h5A;
    localparam logic [BYTE_W-1:0] CASE_OFS  = 8'h20;

    typedef struct packed {
        logic take_item;
        logic load_div;
        logic step_div;
        logic load_out;
    } fks_cmd_t;

    typedef struct packed {
        logic out_free;
    } fks_sts_t;

    function automatic logic [BYTE_W-1:0] fold_lower(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] r;
        r = b;
        if (b >= UPPER_A && b <= UPPER_Z)
        begin
            r = b + CASE_OFS;
        end
        return r;
    endfunction

    // prime 0x100000001B3 = 2^40 + 2^8 + 2^7 + 2^5 + 2^4 + 2^1 + 2^0
    function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
                                                   input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] x;
        x = h ^ {{(HASH_W-BYTE_W){1'b0}}, fold_lower(b)};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

// ===== design/fks_if.sv =====
`timescale 1ns / 1ps
// fks_key_if and fks_shard_if: valid/ready channels for key bytes and results.
// Depends on fks_pkg.
interface fks_key_if;
    import fks_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] key_byte;
    logic              has_byte;
    logic              key_end;

    modport source (output valid, output key_byte, output has_byte, output key_end,
                    input ready);
    modport sink   (input valid, input key_byte, input has_byte, input key_end,
                    output ready);
endinterface

interface fks_shard_if;
    import fks_pkg::*;

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  shard_index;
    logic [HASH_W-1:0] key_hash;

    modport source (output valid, output shard_index, output key_hash, input ready);
    modport sink   (input valid, input shard_index, input key_hash, output ready);
endinterface

// ===== design/fks_ctrl.sv =====
`timescale 1ns / 1ps
// fks_ctrl: sequencer for byte intake, the remainder unit and result loading.
// Depends on fks_pkg.
module fks_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_end,
    output logic              in_ready,
    input  fks_pkg::fks_sts_t sts,
    output fks_pkg::fks_cmd_t cmd
);
    import fks_pkg::*;

    typedef enum logic [1:0] {
        ACCUM,
        DIVIDE,
        DELIVER
    } state_t;

    state_t               state_reg, state_next;
    logic                 ready_reg, ready_next;
    logic [MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 take;

    assign take     = ready_reg && in_valid;
    assign in_ready = ready_reg;

    always_comb
    begin
        state_next   = state_reg;
        ready_next   = ready_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.take_item = take;
        case (state_reg)
            ACCUM:
            begin
                if (take && in_end)
                begin
                    cmd.load_div = 1'b1;
                    state_next   = DIVIDE;
                    ready_next   = 1'b0;
                    cnt_next     = '0;
                end
            end
            DIVIDE:
            begin
                cmd.step_div = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == MOD_CNT_W'(MOD_STEPS - 1))
                begin
                    state_next = DELIVER;
                end
            end
            DELIVER:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ACCUM;
                    ready_next   = 1'b1;
                end
            end
            default:
            begin
                state_next = ACCUM;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ACCUM;
            ready_reg <= 1'b1;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_ready_only_accum: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> state_reg == ACCUM)
        else $error("ready outside ACCUM");

    a_last_starts_divide: assert property (@(posedge clk) disable iff (!rst_n)
        take && in_end |=> state_reg == DIVIDE && cnt_reg == '0 && !ready_reg)
        else $error("last item did not start remainder");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over a pending one");
`endif

endmodule

// ===== design/fks_datapath.sv =====
`timescale 1ns / 1ps
// fks_datapath: running FNV-1a hash, shard count register, 4-bit/cycle
// remainder unit and result register. Depends on fks_pkg.
module fks_datapath
#(
    parameter int unsigned MAX_SHARDS = fks_pkg::MAX_SHARDS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  fks_pkg::fks_cmd_t           cmd,
    output fks_pkg::fks_sts_t           sts,
    input  logic [fks_pkg::BYTE_W-1:0]  key_byte,
    input  logic                        has_byte,
    input  logic                        key_end,
    input  logic                        cfg_we,
    input  logic [fks_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [fks_pkg::IDX_W-1:0]   shard_index,
    output logic [fks_pkg::HASH_W-1:0]  key_hash
);
    import fks_pkg::*;

    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_new;
    logic [HASH_W-1:0] hold_reg;
    logic [HASH_W-1:0] div_reg;
    logic [CFG_W-1:0]  rem_reg, rem_next;
    logic [CFG_W-1:0]  count_reg;
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [HASH_W-1:0] out_hash_reg;

    assign hash_new = (has_byte && key_byte != HYPHEN) ? fnv_step(hash_reg, key_byte)
                                                       : hash_reg;

    always_comb
    begin
        logic [CFG_W:0] t;
        rem_next = rem_reg;
        for (int i = 0; i < MOD_BITS; i++)
        begin
            t = {rem_next, div_reg[HASH_W-1-i]};
            if (t >= {1'b0, count_reg})
            begin
                t = t - {1'b0, count_reg};
            end
            rem_next = t[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= FNV_BASIS;
            count_reg <= CFG_W'(1);
        end
        else
        begin
            if (cmd.take_item)
            begin
                hash_reg <= key_end ? FNV_BASIS : hash_new;
            end
            if (cfg_we && cfg_wdata != '0)
            begin
                count_reg <= (32'(cfg_wdata) > MAX_SHARDS) ? CFG_W'(MAX_SHARDS) : cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_div)
        begin
            div_reg  <= hash_new;
            hold_reg <= hash_new;
            rem_reg  <= '0;
        end
        else if (cmd.step_div)
        begin
            div_reg <= div_reg << MOD_BITS;
            rem_reg <= rem_next;
        end
        if (cmd.load_out)
        begin
            idx_reg      <= rem_reg[IDX_W-1:0];
            out_hash_reg <= hold_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.out_free = !out_valid_reg || out_ready;
    assign out_valid    = out_valid_reg;
    assign shard_index  = idx_reg;
    assign key_hash     = out_hash_reg;

`ifndef ASSERT_OFF
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0)
        else $error("shard count is zero");

    a_zero_write_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_wdata == '0 |=> $stable(count_reg))
        else $error("zero shard count write took effect");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=>
            out_valid_reg && $stable(out_hash_reg) && $stable(idx_reg))
        else $error("stalled result changed");
`endif

endmodule

// ===== design/fnv1a_key_shard_selector.sv =====
`timescale 1ns / 1ps
// fnv1a_key_shard_selector: top level, joins fks_ctrl and fks_datapath.
// Depends on fks_pkg, fks_if, fks_ctrl, fks_datapath.
//
// Usage:
//   key_in carries one key byte per item (key_byte, has_byte, key_end).
//   Bytes are folded to lower case and hashed with 64-bit FNV-1a; a hyphen
//   is skipped, and has_byte = 0 marks an item without a byte.
//   On the item with key_end set, shard_out later carries key_hash and
//   shard_index = key_hash mod the shard count; the hash then restarts.
//   cfg_we/cfg_wdata write the shard count (0 ignored, above MAX_SHARDS clipped);
//   write only while idle.
// Timing:
//   Non-final items: one per cycle, accepted back to back.
//   Final item: the remainder unit consumes 4 dividend bits per cycle, then
//   the result is loaded into the output register and shard_out.valid rises;
//   key_in.ready is low from acceptance until the result is loaded.
//   If shard_out stalls, the result waits in its register; the next key is
//   still accepted, but after its remainder key_in.ready stays low until then.
// Reset: hash returns to the offset basis, shard count to 1, no result held.
module fnv1a_key_shard_selector
#(
    parameter int unsigned MAX_SHARDS = fks_pkg::MAX_SHARDS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    fks_key_if.sink                   key_in,
    fks_shard_if.source               shard_out,
    input  logic                      cfg_we,
    input  logic [fks_pkg::CFG_W-1:0] cfg_wdata
);
    import fks_pkg::*;

    fks_cmd_t cmd;
    fks_sts_t sts;

    fks_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (key_in.valid),
        .in_end   (key_in.key_end),
        .in_ready (key_in.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fks_datapath #(
        .MAX_SHARDS (MAX_SHARDS)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .key_byte    (key_in.key_byte),
        .has_byte    (key_in.has_byte),
        .key_end     (key_in.key_end),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .out_ready   (shard_out.ready),
        .out_valid   (shard_out.valid),
        .shard_index (shard_out.shard_index),
        .key_hash    (shard_out.key_hash)
    );

endmodule
